### rtl/fct_pkg.sv
`timescale 1ns / 1ps
// fct_pkg: shared types and constants for the frustum cull test block
// no dependencies; imported by every module under rtl

package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int FRAC_BITS   = 14;
    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int PROD_W      = 2 * COORD_W;
    // three products plus the offset term plus the radius term
    localparam int DIST_W      = PROD_W + 3;
    localparam int IDX_W       = $clog2(PLANE_COUNT);
    localparam int PLANE_W     = 4 * COORD_W;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2,
        OP_NONE   = 2'd3
    } fct_op_t;

    typedef logic signed [COORD_W-1:0] fct_coord_t;
    typedef logic signed [PROD_W-1:0]  fct_prod_t;
    typedef logic signed [DIST_W-1:0]  fct_dist_t;

    // packed {w, nz, ny, nx}, 16 bits each
    typedef struct packed {
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } fct_plane_t;

    typedef struct packed {
        fct_coord_t first_x;
        fct_coord_t first_y;
        fct_coord_t first_z;
        fct_coord_t second_x;
        fct_coord_t second_y;
        fct_coord_t second_z;
    } fct_query_t;

    typedef struct packed {
        logic pos;
        logic sphere_ok;
        logic box_ok;
    } fct_flags_t;

endpackage

### rtl/fct_plane_regs.sv
`timescale 1ns / 1ps
// fct_plane_regs: the six plane registers behind the configuration write port
// depends on fct_pkg

module fct_plane_regs
    import fct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [PLANE_W-1:0]   cfg_data,
    output fct_plane_t           planes [PLANE_COUNT]
);

    fct_plane_t planes_reg [PLANE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                planes_reg[i] <= '0;
            end
        end
        else if (cfg_write && (cfg_index < IDX_W'(PLANE_COUNT)))
        begin
            planes_reg[cfg_index] <= fct_plane_t'(cfg_data);
        end
    end

    always_comb
    begin
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            planes[i] = planes_reg[i];
        end
    end

endmodule

### rtl/fct_plane_unit.sv
`timescale 1ns / 1ps
// fct_plane_unit: registered products of one plane with the query, then
// distance sums and the three pass flags; depends on fct_pkg

module fct_plane_unit
    import fct_pkg::*;
(
    input  logic                clk,
    input  fct_plane_t          plane,
    input  fct_query_t          query,
    input  logic [RADIUS_W-1:0] radius,
    output fct_flags_t          flags
);

    fct_prod_t px_a_reg, py_a_reg, pz_a_reg;
    fct_prod_t px_b_reg, py_b_reg, pz_b_reg;
    fct_prod_t px_a_next, py_a_next, pz_a_next;
    fct_prod_t px_b_next, py_b_next, pz_b_next;

    fct_prod_t mx, my, mz;
    fct_dist_t w_term, r_term, d_first, d_box, d_sphere;

    always_comb
    begin
        px_a_next = PROD_W'(plane.nx) * PROD_W'(query.first_x);
        py_a_next = PROD_W'(plane.ny) * PROD_W'(query.first_y);
        pz_a_next = PROD_W'(plane.nz) * PROD_W'(query.first_z);
        px_b_next = PROD_W'(plane.nx) * PROD_W'(query.second_x);
        py_b_next = PROD_W'(plane.ny) * PROD_W'(query.second_y);
        pz_b_next = PROD_W'(plane.nz) * PROD_W'(query.second_z);
    end

    always_ff @(posedge clk)
    begin
        px_a_reg <= px_a_next;
        py_a_reg <= py_a_next;
        pz_a_reg <= pz_a_next;
        px_b_reg <= px_b_next;
        py_b_reg <= py_b_next;
        pz_b_reg <= pz_b_next;
    end

    // farthest box corner along the normal: larger product on each axis
    always_comb
    begin
        mx = (px_a_reg > px_b_reg) ? px_a_reg : px_b_reg;
        my = (py_a_reg > py_b_reg) ? py_a_reg : py_b_reg;
        mz = (pz_a_reg > pz_b_reg) ? pz_a_reg : pz_b_reg;

        w_term   = DIST_W'(plane.w) <<< FRAC_BITS;
        r_term   = DIST_W'(radius) << FRAC_BITS;
        d_first  = DIST_W'(px_a_reg) + DIST_W'(py_a_reg) + DIST_W'(pz_a_reg) + w_term;
        d_box    = DIST_W'(mx) + DIST_W'(my) + DIST_W'(mz) + w_term;
        d_sphere = d_first + r_term;

        flags.pos       = (d_first > 0);
        flags.sphere_ok = !d_sphere[DIST_W-1];
        flags.box_ok    = !d_box[DIST_W-1];
    end

endmodule

### rtl/frustum_cull_test.sv
`timescale 1ns / 1ps
// frustum_cull_test: top level, query pipeline and result combine
// depends on fct_pkg, fct_plane_regs, fct_plane_unit
//
// usage:
//   request: pulse start with operation, first_*, second_*, radius; a
//   request is taken at every edge with start high (busy stays low, the
//   pipeline takes one request per cycle with no gaps).
//   result: done is high for one cycle with inside_res valid, once the request
//   has passed the input register, product register and result register;
//   in request order.
//   config: cfg_valid/cfg_ready write plane cfg_index with cfg_data;
//   cfg_ready is always high, indexes above 5 are dropped. write planes
//   only while no request is in flight.
//   throughput: one request per clock; the three register stages lie
//   around the 16x16 multipliers of each plane.
//   reset: rst_n clears the pipeline valids and all six planes to zero.
//   the receiver cannot stall: done and inside_res are shown one cycle only.

module frustum_cull_test
    import fct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           operation,
    input  logic signed [15:0]   first_x,
    input  logic signed [15:0]   first_y,
    input  logic signed [15:0]   first_z,
    input  logic signed [15:0]   second_x,
    input  logic signed [15:0]   second_y,
    input  logic signed [15:0]   second_z,
    input  logic [14:0]          radius,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [PLANE_W-1:0]   cfg_data,
    output logic                 done,
    output logic                 inside_res
);

    fct_plane_t planes [PLANE_COUNT];
    fct_flags_t flags  [PLANE_COUNT];

    logic                valid_s1_reg, valid_s2_reg;
    fct_op_t             op_s1_reg, op_s2_reg;
    logic [RADIUS_W-1:0] radius_s1_reg, radius_s2_reg;
    fct_query_t          query_s1_reg;

    logic                done_reg;
    logic                inside_reg, inside_next;
    logic                all_pos, all_sphere, all_box;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    fct_plane_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_plane
        fct_plane_unit u_unit (
            .clk    (clk),
            .plane  (planes[g]),
            .query  (query_s1_reg),
            .radius (radius_s2_reg),
            .flags  (flags[g])
        );
    end

    // control: request valids and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= start && !busy;
            valid_s2_reg <= valid_s1_reg;
            done_reg     <= valid_s2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        op_s1_reg              <= fct_op_t'(operation);
        radius_s1_reg          <= radius;
        query_s1_reg.first_x   <= first_x;
        query_s1_reg.first_y   <= first_y;
        query_s1_reg.first_z   <= first_z;
        query_s1_reg.second_x  <= second_x;
        query_s1_reg.second_y  <= second_y;
        query_s1_reg.second_z  <= second_z;
        op_s2_reg              <= op_s1_reg;
        radius_s2_reg          <= radius_s1_reg;
        inside_reg             <= inside_next;
    end

    always_comb
    begin
        all_pos    = 1'b1;
        all_sphere = 1'b1;
        all_box    = 1'b1;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            all_pos    = all_pos    && flags[i].pos;
            all_sphere = all_sphere && flags[i].sphere_ok;
            all_box    = all_box    && flags[i].box_ok;
        end

        unique case (op_s2_reg)
            OP_POINT:  inside_next = all_pos;
            OP_SPHERE: inside_next = all_sphere;
            OP_BOX:    inside_next = all_box;
            OP_NONE:   inside_next = 1'b0;
            default:   inside_next = 1'b0;
        endcase
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("request did not produce a result three cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_s1_reg, 2))
        else $error("result strobe without a request");

    a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_s2_reg && (op_s2_reg == OP_NONE)) |=> (done && !inside_res))
        else $error("undefined operation reported inside");
`endif

endmodule

### sim/tb_frustum_cull_test.sv
`timescale 1ns / 1ps
// tb_frustum_cull_test: self-checking bench for the frustum cull test block
// depends on fct_pkg and frustum_cull_test; point, sphere and box queries
// are checked against an in-bench predictor of the six plane distances

module tb_frustum_cull_test
    import fct_pkg::*;
;

    localparam int STALL_LIMIT = 2000;

    typedef enum logic [IDX_W-1:0] {
        REG_RIGHT  = 3'd0,
        REG_LEFT   = 3'd1,
        REG_TOP    = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_BACK   = 3'd4,
        REG_FRONT  = 3'd5,
        REG_SPARE0 = 3'd6,
        REG_SPARE1 = 3'd7
    } plane_reg_t;

    typedef struct packed {
        fct_op_t               op;
        fct_query_t            coords;
        logic [RADIUS_W-1:0]   radius;
    } cull_query_t;

    class cull_scoreboard;
        fct_plane_t planes [PLANE_COUNT];
        bit         expected_inside [$];
        int         errors;

        function new();
            foreach (planes[i])
                planes[i] = '0;
            errors = 0;
        endfunction

        function void set_plane(int unsigned idx, logic [PLANE_W-1:0] data);
            if (idx < PLANE_COUNT)
                planes[idx] = data;
        endfunction

        // exact n.p + w in q.14
        function longint distance(fct_plane_t p, fct_coord_t x, fct_coord_t y,
                                  fct_coord_t z);
            longint dx, dy, dz, ofs, px, py, pz;
            dx = 64'(p.nx);
            dy = 64'(p.ny);
            dz = 64'(p.nz);
            ofs = 64'(p.w);
            px = 64'(x);
            py = 64'(y);
            pz = 64'(z);
            return dx * px + dy * py + dz * pz + (ofs <<< FRAC_BITS);
        endfunction

        function bit predict_inside(cull_query_t q);
            longint     lim;
            bit         verdict, hit;
            fct_coord_t x, y, z;
            verdict = 1'b0;
            case (q.op)
                OP_POINT: begin
                    verdict = 1'b1;
                    foreach (planes[i])
                        if (distance(planes[i], q.coords.first_x, q.coords.first_y,
                                     q.coords.first_z) <= 0)
                            verdict = 1'b0;
                end
                OP_SPHERE: begin
                    lim = 64'(q.radius);
                    lim = -(lim <<< FRAC_BITS);
                    verdict = 1'b1;
                    foreach (planes[i])
                        if (distance(planes[i], q.coords.first_x, q.coords.first_y,
                                     q.coords.first_z) < lim)
                            verdict = 1'b0;
                end
                OP_BOX: begin
                    verdict = 1'b1;
                    foreach (planes[i]) begin
                        hit = 1'b0;
                        for (int c = 0; c < 8; c++) begin
                            x = ((c & 1) != 0) ? q.coords.second_x : q.coords.first_x;
                            y = ((c & 2) != 0) ? q.coords.second_y : q.coords.first_y;
                            z = ((c & 4) != 0) ? q.coords.second_z : q.coords.first_z;
                            if (distance(planes[i], x, y, z) >= 0)
                                hit = 1'b1;
                        end
                        if (!hit)
                            verdict = 1'b0;
                    end
                end
                default: verdict = 1'b0;
            endcase
            return verdict;
        endfunction

        function void note_query(cull_query_t q);
            expected_inside.push_back(predict_inside(q));
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (expected_inside.size() == 0)
            begin
                $error("inside_res: no request outstanding, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_inside.pop_front();
                if (got !== want)
                begin
                    $error("inside_res mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_inside.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           operation;
    fct_coord_t           first_x, first_y, first_z;
    fct_coord_t           second_x, second_y, second_z;
    logic [RADIUS_W-1:0]  radius;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [PLANE_W-1:0]   cfg_data;
    logic                 done;
    logic                 inside_res;

    cull_scoreboard       sb = new();
    int                   stall_cycles = 0;
    logic                 activity;
    cull_query_t          seen;
    logic [PLANE_W-1:0]   plane_set [PLANE_COUNT];

    frustum_cull_test dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .first_x    (first_x),
        .first_y    (first_y),
        .first_z    (first_z),
        .second_x   (second_x),
        .second_y   (second_y),
        .second_z   (second_z),
        .radius     (radius),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .inside_res (inside_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        activity = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                seen.op = fct_op_t'(operation);
                seen.coords = {first_x, first_y, first_z, second_x, second_y, second_z};
                seen.radius = radius;
                sb.note_query(seen);
                activity = 1'b1;
            end
            if (done)
            begin
                sb.check_verdict(inside_res);
                activity = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.set_plane(32'(cfg_index), cfg_data);
                activity = 1'b1;
            end
        end
        stall_cycles <= activity ? 0 : stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic cull_query_t make_query(fct_op_t op, int ax, int ay, int az,
                                               int bx, int by, int bz, int r);
        cull_query_t q;
        q.op = op;
        q.coords = {16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz)};
        q.radius = 15'(r);
        return q;
    endfunction

    function automatic logic [PLANE_W-1:0] make_plane(int nx, int ny, int nz, int w);
        return {16'(w), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic fct_coord_t rand_coord(int span);
        if (span == 0 || $urandom_range(0, 9) < 3)
            return fct_coord_t'($urandom);
        return fct_coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic cull_query_t rand_query(int span);
        cull_query_t q;
        fct_coord_t  lo [3];
        fct_coord_t  hi [3];
        fct_coord_t  t;
        int          pick;
        bit          ordered;
        pick = $urandom_range(0, 19);
        q.op = (pick == 0) ? OP_NONE : fct_op_t'(pick % 3);
        ordered = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = rand_coord(span);
            hi[k] = rand_coord(span);
            // mostly well-formed boxes, some with swapped bounds
            if (ordered && lo[k] > hi[k])
            begin
                t = lo[k];
                lo[k] = hi[k];
                hi[k] = t;
            end
        end
        q.coords = {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
        if (span != 0 && $urandom_range(0, 9) < 7)
            q.radius = RADIUS_W'($urandom_range(0, span));
        else
            q.radius = RADIUS_W'($urandom_range(0, 32767));
        return q;
    endfunction

    task automatic send_query(cull_query_t q);
        @(negedge clk);
        start     <= 1'b1;
        operation <= q.op;
        first_x   <= q.coords.first_x;
        first_y   <= q.coords.first_y;
        first_z   <= q.coords.first_z;
        second_x  <= q.coords.second_x;
        second_y  <= q.coords.second_y;
        second_z  <= q.coords.second_z;
        radius    <= q.radius;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_for(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic write_plane(plane_reg_t idx, logic [PLANE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every outstanding request come back before touching the planes
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_planes();
        for (int i = 0; i < PLANE_COUNT; i++)
            write_plane(plane_reg_t'(i), plane_set[i]);
        // out-of-range index must leave the planes alone
        write_plane(($urandom_range(0, 1) != 0) ? REG_SPARE1 : REG_SPARE0,
                    {$urandom, $urandom});
    endtask

    task automatic set_box_frustum(int half);
        plane_set[REG_RIGHT]  = make_plane(-16384, 0, 0, half);
        plane_set[REG_LEFT]   = make_plane(16384, 0, 0, half);
        plane_set[REG_TOP]    = make_plane(0, -16384, 0, half);
        plane_set[REG_BOTTOM] = make_plane(0, 16384, 0, half);
        plane_set[REG_BACK]   = make_plane(0, 0, -16384, half);
        plane_set[REG_FRONT]  = make_plane(0, 0, 16384, half);
    endtask

    task automatic run_phase(int count, int span, bit with_gaps);
        for (int i = 0; i < count; i++)
        begin
            send_query(rand_query(span));
            if (with_gaps && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 11));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_POINT;
        first_x   = '0;
        first_y   = '0;
        first_z   = '0;
        second_x  = '0;
        second_y  = '0;
        second_z  = '0;
        radius    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RIGHT;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // planes still zero: spare writes are dropped, point and none fail, sphere and box pass
        write_plane(REG_SPARE0, '1);
        write_plane(REG_SPARE1, {$urandom, $urandom});
        send_query(make_query(OP_POINT, 32767, -32768, 1, 0, 0, 0, 0));
        send_query(make_query(OP_SPHERE, -32768, 32767, 0, 0, 0, 0, 32767));
        send_query(make_query(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_query(make_query(OP_NONE, 5, 5, 5, 6, 6, 6, 100));
        drain();

        set_box_frustum(1000);
        load_planes();
        send_query(make_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(OP_POINT, 1000, 0, 0, -1, -1, -1, 32767));
        send_query(make_query(OP_POINT, 999, -999, 999, 0, 0, 0, 0));
        send_query(make_query(OP_POINT, -1001, 0, 0, 0, 0, 0, 0));
        // sphere touching the plane from outside at exactly the radius
        send_query(make_query(OP_SPHERE, 1000, 0, 0, 0, 0, 0, 0));
        send_query(make_query(OP_SPHERE, 1005, 0, 0, 0, 0, 0, 5));
        send_query(make_query(OP_SPHERE, 1005, 0, 0, 0, 0, 0, 4));
        send_query(make_query(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
        send_query(make_query(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
        send_query(make_query(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_query(make_query(OP_BOX, 2000, 0, 0, 3000, 10, 10, 0));
        send_query(make_query(OP_BOX, 1000, -5, -5, 1200, 5, 5, 0));
        // swapped bounds, corners taken as given
        send_query(make_query(OP_BOX, 500, 500, 500, -500, -500, -500, 0));
        send_query(make_query(OP_BOX, 3000, 3000, 3000, 2000, 2000, 2000, 0));
        send_query(make_query(OP_NONE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(OP_NONE, -1, -1, -1, -1, -1, -1, 32767));
        run_phase(80, 1500, 1'b1);
        drain();

        for (int i = 0; i < PLANE_COUNT; i++)
            plane_set[i] = make_plane(int'($urandom_range(0, 32768)) - 16384,
                                      int'($urandom_range(0, 32768)) - 16384,
                                      int'($urandom_range(0, 32768)) - 16384,
                                      int'($urandom_range(0, 4000)) - 2000);
        load_planes();
        run_phase(80, 2000, 1'b1);
        drain();

        for (int i = 0; i < PLANE_COUNT; i++)
            plane_set[i] = {$urandom, $urandom};
        load_planes();
        run_phase(80, 0, 1'b1);
        drain();

        plane_set[REG_RIGHT]  = 64'h7FFF_7FFF_7FFF_7FFF;
        plane_set[REG_LEFT]   = 64'h8000_8000_8000_8000;
        plane_set[REG_TOP]    = 64'hFFFF_FFFF_FFFF_FFFF;
        plane_set[REG_BOTTOM] = 64'h8000_7FFF_8000_7FFF;
        plane_set[REG_BACK]   = 64'h7FFF_8000_7FFF_8000;
        plane_set[REG_FRONT]  = 64'h0000_0000_0000_0000;
        load_planes();
        run_phase(80, 0, 1'b1);
        drain();

        // closing stretch at full rate
        set_box_frustum(500);
        load_planes();
        run_phase(80, 800, 1'b0);
        drain();
        repeat (6) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/fct_pkg.sv
rtl/fct_plane_regs.sv
rtl/fct_plane_unit.sv
rtl/frustum_cull_test.sv
sim/tb_frustum_cull_test.sv
